>>> hdl/presence_table_with_aging_assert.svh
// Assertion macros for the presence table, empty in synthesis builds
`ifndef PRESENCE_TABLE_WITH_AGING_ASSERT_SVH
`define PRESENCE_TABLE_WITH_AGING_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is active
`define PTA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("presence table check failed");

// Clocked check that also holds during reset
`define PTA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("presence table check failed");

`else

`define PTA_ASSERT(lbl, clk, rstn, prop)
`define PTA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hdl/pta_pkg.sv
// Shared types and constants of the presence table
package pta_pkg;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Operation codes; the high bit alone selects a tick
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_RELOAD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_STEP     = 2'd1;

  localparam logic [15:0] TIMEOUT_RELOAD_RST = 16'd1000;
  localparam logic [15:0] DECAY_STEP_RST     = 16'd1;

  typedef enum logic [2:0] {
    ST_ADDED       = 3'd0,
    ST_ADDED_CLASH = 3'd1,
    ST_REFRESHED   = 3'd2,
    ST_REMOVED     = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_NOT_FOUND   = 3'd5,
    ST_TICKED      = 3'd6,
    ST_FULL        = 3'd7
  } status_e;

  // One table slot as held in the memory
  typedef struct packed {
    logic        valid;
    logic [15:0] id;
    logic [63:0] name;
    logic [7:0]  activity;
    logic [15:0] timeout;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;      // write an empty slot at the sweep address
    logic load_item;  // capture the accepted item, clear scan flags
    logic read;       // read the slot at the sweep address
    logic finish;     // add write if due, and load the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic addr_last;  // sweep address is the last slot
    logic out_busy;   // result register full and not taken this cycle
  } stat_t;

endpackage

>>> hdl/presence_table_with_aging.sv
// Presence table with aging: top level
//
// Input stream: one item is an operation in tuser (insert or refresh,
// remove by id, aging tick) with node id, name tag and activity in tdata.
// Output stream: one result item per input item, carrying status, id_found
// and name_seen.
// Configuration channel, always ready: sets reload timeout (index 0) and decay
// step (index 1). The user writes it only while idle; no logic enforces this.
//
// An accepted item keeps the input busy: one slot of the table memory is read
// per cycle through its single read port, then a drain state takes the last
// read data and a finish state, which waits while the result register is busy,
// writes a new slot for an add and loads the result. The input is ready again
// after the finish state, and the result is visible from the cycle after it.
//
// After reset the table memory is swept once, one slot per cycle, to mark
// every slot free; the input is not ready until the sweep ends.
// A result waiting on a stalled receiver does not block the next input item;
// that item's scan runs and its result is held until the register is free.
`include "presence_table_with_aging_assert.svh"

module presence_table_with_aging #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [15:0] node_id, [79:16] name_tag, [87:80] activity_value
  input  logic [pta_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] operation
  input  logic [pta_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  // master side
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [2:0] status, [3] id_found, [4] name_seen, [7:5] zero
  output logic [pta_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pta_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [pta_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  pta_pkg::cmd_t  cmd;
  pta_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  pta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pta_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_tdata_i  (s_axis_tdata_i),
    .in_tuser_i  (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tdata_o (m_axis_tdata_o)
  );

  // Checks
  `PTA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
  `PTA_ASSERT(a_finish_shows_result, clk_i, rst_ni, cmd.finish |=> m_axis_tvalid_o)
  `PTA_ASSERT(a_one_command, clk_i, rst_ni, $onehot0(cmd))
  `PTA_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

>>> hdl/pta_ram.sv
// Generic single-write, single-read RAM with registered read data
module pta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/pta_ctrl.sv
// Controller state machine of the presence table
module pta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pta_pkg::stat_t stat_i,
  output pta_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.addr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.read = 1'b1;
        if (stat_i.addr_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register can take the item
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/pta_dpath.sv
// Datapath of the presence table: slot memory, scan flags, config and result
module pta_dpath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pta_pkg::cmd_t                    cmd_i,
  output pta_pkg::stat_t                   stat_o,
  input  logic [pta_pkg::IN_TDATA_W-1:0]   in_tdata_i,
  input  logic [pta_pkg::IN_TUSER_W-1:0]   in_tuser_i,
  input  logic                             cfg_valid_i,
  input  logic [pta_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [pta_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pta_pkg::OUT_TDATA_W-1:0]  out_tdata_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_ENTRIES - 1);

  // Configuration registers
  logic [15:0] reload_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= pta_pkg::TIMEOUT_RELOAD_RST;
      step_q   <= pta_pkg::DECAY_STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pta_pkg::CFG_TIMEOUT_RELOAD: reload_q <= cfg_data_i;
        pta_pkg::CFG_DECAY_STEP:     step_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Captured item
  logic [1:0]  op_q;
  logic [15:0] id_q;
  logic [63:0] name_q;
  logic [7:0]  act_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= in_tuser_i;
      id_q   <= in_tdata_i[15:0];
      name_q <= in_tdata_i[79:16];
      act_q  <= in_tdata_i[87:80];
    end
  end

  logic is_tick, is_remove;
  // high bit selects a tick, so code 3 ticks as well
  assign is_tick   = op_q[1];
  assign is_remove = (op_q == pta_pkg::OP_REMOVE);

  // Sweep address and read pipeline
  logic [AW-1:0] addr_q, rd_addr_q;
  logic          rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.read;
      if (cmd_i.clear || cmd_i.read) begin
        addr_q <= (addr_q == LastAddr) ? '0 : addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= addr_q;
  end

  // Slot memory
  pta_pkg::entry_t rdata, wdata;
  logic            we;
  logic [AW-1:0]   waddr;

  pta_ram #(
    .WIDTH ($bits(pta_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.read),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // Scan flags
  logic          found_q, found_d;
  logic          seen_q, seen_d;
  logic          any_q, any_d;
  logic          free_q, free_d;
  logic [AW-1:0] free_idx_q, free_idx_d;

  logic id_hit, name_hit;
  assign id_hit   = rdata.valid && (rdata.id == id_q);
  assign name_hit = rdata.valid && (rdata.name == name_q);

  // Per-slot update, final add write
  always_comb begin
    found_d    = found_q;
    seen_d     = seen_q;
    any_d      = any_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    we         = 1'b0;
    waddr      = rd_addr_q;
    wdata      = rdata;
    if (cmd_i.load_item) begin
      found_d = 1'b0;
      seen_d  = 1'b0;
      any_d   = 1'b0;
      free_d  = 1'b0;
    end
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = addr_q;
      wdata = '0;
    end else if (rd_vld_q) begin
      if (is_tick) begin
        // saturating decay of each live slot
        we            = rdata.valid;
        wdata.timeout = (rdata.timeout > step_q) ? rdata.timeout - step_q : '0;
      end else if (is_remove) begin
        any_d = any_q | rdata.valid;
        if (id_hit && !found_q) begin
          found_d     = 1'b1;
          we          = 1'b1;
          wdata.valid = 1'b0;
        end
      end else begin
        // refresh on id match, note name clash and first free slot
        if (id_hit) begin
          found_d        = 1'b1;
          we             = 1'b1;
          wdata.activity = act_q;
          wdata.timeout  = reload_q;
        end
        if (name_hit) begin
          seen_d = 1'b1;
        end
        if (!rdata.valid && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = rd_addr_q;
        end
      end
    end else if (cmd_i.finish && !is_tick && !is_remove && !found_q && free_q) begin
      we             = 1'b1;
      waddr          = free_idx_q;
      wdata.valid    = 1'b1;
      wdata.id       = id_q;
      wdata.name     = name_q;
      wdata.activity = act_q;
      wdata.timeout  = reload_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      seen_q  <= 1'b0;
      any_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      found_q <= found_d;
      seen_q  <= seen_d;
      any_q   <= any_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
  end

  // Result decision
  pta_pkg::status_e res_status;
  logic             res_idf, res_nms;

  always_comb begin
    res_idf = 1'b0;
    res_nms = 1'b0;
    if (is_tick) begin
      res_status = pta_pkg::ST_TICKED;
    end else if (is_remove) begin
      if (!any_q) begin
        res_status = pta_pkg::ST_EMPTY;
      end else if (found_q) begin
        res_status = pta_pkg::ST_REMOVED;
        res_idf    = 1'b1;
      end else begin
        res_status = pta_pkg::ST_NOT_FOUND;
      end
    end else begin
      res_nms = seen_q;
      if (found_q) begin
        res_status = pta_pkg::ST_REFRESHED;
        res_idf    = 1'b1;
      end else if (!free_q) begin
        res_status = pta_pkg::ST_FULL;
      end else if (seen_q) begin
        res_status = pta_pkg::ST_ADDED_CLASH;
      end else begin
        res_status = pta_pkg::ST_ADDED;
      end
    end
  end

  // Output register
  logic                            out_valid_q;
  logic [pta_pkg::OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {3'b000, res_nms, res_idf, res_status};
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_tdata_o      = out_data_q;
  assign stat_o.addr_last = (addr_q == LastAddr);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

endmodule
